// ----- src/pshm_pkg.sv -----
// ----------------------------------------------------------------------------
// pshm_pkg: shared types and constants of the pose stream health monitor
// Field widths, register map, verdict codes and control structures.
// ----------------------------------------------------------------------------
package pshm_pkg;

	// Arrival window
	localparam int RING_DEPTH = 128;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);

	// Field widths
	localparam int TIME_W  = 48;
	localparam int POS_W   = 24;
	localparam int VAR_W   = 32;
	localparam int TRACE_W = 33;
	localparam int JUMP_W  = 49;
	localparam int SPAN_W  = 21;
	localparam int COUNT_W = 8;
	localparam int ABS_W   = POS_W + 1;
	localparam int SQ_W    = 2 * ABS_W;
	localparam int TMO_W   = 26;
	localparam int JLIM_W  = 32;
	localparam int RPROD_W = 26;
	localparam int RATE_W  = 48;

	// Configuration port
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam int RATE_CFG_W  = 17;
	localparam int RATIO_W     = 9;
	localparam int TIMEOUT_W   = 16;
	localparam int MAXJUMP_W   = 16;

	localparam logic [TIME_W-1:0] WINDOW_US = TIME_W'(2000000);
	localparam logic [TMO_W-1:0]  MS_TO_US  = TMO_W'(1000);
	// 1e8 (0.01 Hz per Hz times microseconds per second) times 256 for the ratio scale.
	localparam logic [RATE_W-1:0] RATE_K    = RATE_W'(64'd25600000000);

	localparam logic [RATE_CFG_W-1:0] RST_EXPECTED_RATE = RATE_CFG_W'(3000);
	localparam logic [RATIO_W-1:0]    RST_WARN_RATIO    = RATIO_W'(179);
	localparam logic [RATIO_W-1:0]    RST_ERROR_RATIO   = RATIO_W'(102);
	localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT_MS    = TIMEOUT_W'(1000);
	localparam logic [TRACE_W-1:0]    RST_TRACE_WARN    = TRACE_W'(65536);
	localparam logic [TRACE_W-1:0]    RST_TRACE_ERROR   = TRACE_W'(589824);
	localparam logic [MAXJUMP_W-1:0]  RST_MAX_JUMP      = MAXJUMP_W'(2000);

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_POLL   = 1'b1;

	typedef enum logic [2:0] {
		REG_EXPECTED_RATE = 3'd0,
		REG_WARN_RATIO    = 3'd1,
		REG_ERROR_RATIO   = 3'd2,
		REG_TIMEOUT_MS    = 3'd3,
		REG_TRACE_WARN    = 3'd4,
		REG_TRACE_ERROR   = 3'd5,
		REG_MAX_JUMP      = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		LVL_OK    = 2'd0,
		LVL_WARN  = 2'd1,
		LVL_ERROR = 2'd2,
		LVL_STALE = 2'd3
	} level_t;

	typedef enum logic [2:0] {
		CAUSE_OK        = 3'd0,
		CAUSE_NONE_YET  = 3'd1,
		CAUSE_TIMEOUT   = 3'd2,
		CAUSE_JUMP      = 3'd3,
		CAUSE_COV_CRIT  = 3'd4,
		CAUSE_COV_HIGH  = 3'd5,
		CAUSE_RATE_CRIT = 3'd6,
		CAUSE_RATE_LOW  = 3'd7
	} cause_t;

	typedef struct packed {
		logic [RATE_CFG_W-1:0] expected_rate;
		logic [RATIO_W-1:0]    rate_warn_ratio;
		logic [RATIO_W-1:0]    rate_error_ratio;
		logic [TIMEOUT_W-1:0]  stale_timeout_ms;
		logic [TRACE_W-1:0]    trace_warn_limit;
		logic [TRACE_W-1:0]    trace_error_limit;
		logic [MAXJUMP_W-1:0]  max_jump_mm;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              shift;
		logic [TIME_W-1:0] wdata;
	} cell_ctl_t;

	typedef struct packed {
		logic               seen;
		logic [TIME_W-1:0]  age;
		logic [TMO_W-1:0]   tmo;
		logic               jump_on;
		logic [JUMP_W-1:0]  jump_sq;
		logic [JLIM_W-1:0]  jump_lim;
		logic [TRACE_W-1:0] trace;
		logic [TRACE_W-1:0] trace_warn;
		logic [TRACE_W-1:0] trace_err;
		logic               rate_on;
		logic               err_on;
		logic               warn_on;
		logic [RATE_W-1:0]  lhs;
		logic [RATE_W-1:0]  rhs_err;
		logic [RATE_W-1:0]  rhs_warn;
	} grade_in_t;

endpackage

// ----- src/pshm_cell.sv -----
// ----------------------------------------------------------------------------
// pshm_cell: one slot of the arrival window chain
// Holds one arrival time; loads a new time or takes its newer neighbor's.
// ----------------------------------------------------------------------------
module pshm_cell (
	input  logic                              clk,
	input  pshm_pkg::cell_ctl_t               ctl,
	input  logic                              sel,
	input  logic [pshm_pkg::TIME_W-1:0]       nbr,
	output logic [pshm_pkg::TIME_W-1:0]       entry_q
);

	// A load into the selected slot wins over the shift toward the head.
	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			entry_q <= ctl.wdata;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end
	end

endmodule

// ----- src/pshm_regs.sv -----
// ----------------------------------------------------------------------------
// pshm_regs: configuration register file
// APB-style write and read of the seven monitor thresholds.
// ----------------------------------------------------------------------------
module pshm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pshm_pkg::ADDR_W-1:0]   paddr,
	input  logic [pshm_pkg::DATA_W-1:0]   pwdata,
	output logic [pshm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pshm_pkg::cfg_t                cfg
);

	pshm_pkg::cfg_t     cfg_q;
	pshm_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = pshm_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_rate     <= pshm_pkg::RST_EXPECTED_RATE;
			cfg_q.rate_warn_ratio   <= pshm_pkg::RST_WARN_RATIO;
			cfg_q.rate_error_ratio  <= pshm_pkg::RST_ERROR_RATIO;
			cfg_q.stale_timeout_ms  <= pshm_pkg::RST_TIMEOUT_MS;
			cfg_q.trace_warn_limit  <= pshm_pkg::RST_TRACE_WARN;
			cfg_q.trace_error_limit <= pshm_pkg::RST_TRACE_ERROR;
			cfg_q.max_jump_mm       <= pshm_pkg::RST_MAX_JUMP;
		end else if (wr_en) begin
			unique case (idx)
				pshm_pkg::REG_EXPECTED_RATE: begin
					cfg_q.expected_rate <= pwdata[pshm_pkg::RATE_CFG_W-1:0];
				end
				pshm_pkg::REG_WARN_RATIO: begin
					cfg_q.rate_warn_ratio <= pwdata[pshm_pkg::RATIO_W-1:0];
				end
				pshm_pkg::REG_ERROR_RATIO: begin
					cfg_q.rate_error_ratio <= pwdata[pshm_pkg::RATIO_W-1:0];
				end
				pshm_pkg::REG_TIMEOUT_MS: begin
					cfg_q.stale_timeout_ms <= pwdata[pshm_pkg::TIMEOUT_W-1:0];
				end
				pshm_pkg::REG_TRACE_WARN: begin
					cfg_q.trace_warn_limit <= pwdata[pshm_pkg::TRACE_W-1:0];
				end
				pshm_pkg::REG_TRACE_ERROR: begin
					cfg_q.trace_error_limit <= pwdata[pshm_pkg::TRACE_W-1:0];
				end
				pshm_pkg::REG_MAX_JUMP: begin
					cfg_q.max_jump_mm <= pwdata[pshm_pkg::MAXJUMP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pshm_pkg::REG_EXPECTED_RATE: prdata = pshm_pkg::DATA_W'(cfg_q.expected_rate);
			pshm_pkg::REG_WARN_RATIO:    prdata = pshm_pkg::DATA_W'(cfg_q.rate_warn_ratio);
			pshm_pkg::REG_ERROR_RATIO:   prdata = pshm_pkg::DATA_W'(cfg_q.rate_error_ratio);
			pshm_pkg::REG_TIMEOUT_MS:    prdata = pshm_pkg::DATA_W'(cfg_q.stale_timeout_ms);
			pshm_pkg::REG_TRACE_WARN:    prdata = pshm_pkg::DATA_W'(cfg_q.trace_warn_limit);
			pshm_pkg::REG_TRACE_ERROR:   prdata = pshm_pkg::DATA_W'(cfg_q.trace_error_limit);
			pshm_pkg::REG_MAX_JUMP:      prdata = pshm_pkg::DATA_W'(cfg_q.max_jump_mm);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ----- src/pshm_grade.sv -----
// ----------------------------------------------------------------------------
// pshm_grade: health verdict grading
// Stale, jump, covariance and rate checks merged by level, earlier cause first.
// ----------------------------------------------------------------------------
module pshm_grade (
	input  pshm_pkg::grade_in_t gi,
	output pshm_pkg::level_t    level,
	output pshm_pkg::cause_t    cause
);

	pshm_pkg::level_t t_lvl;
	pshm_pkg::cause_t t_cause;
	pshm_pkg::level_t r_lvl;
	pshm_pkg::cause_t r_cause;

	always_comb begin
		t_lvl   = pshm_pkg::LVL_OK;
		t_cause = pshm_pkg::CAUSE_OK;
		if (gi.trace > gi.trace_err) begin
			t_lvl   = pshm_pkg::LVL_ERROR;
			t_cause = pshm_pkg::CAUSE_COV_CRIT;
		end else if (gi.trace > gi.trace_warn) begin
			t_lvl   = pshm_pkg::LVL_WARN;
			t_cause = pshm_pkg::CAUSE_COV_HIGH;
		end

		// A zero measured rate fails any nonzero ratio threshold.
		r_lvl   = pshm_pkg::LVL_OK;
		r_cause = pshm_pkg::CAUSE_OK;
		if (gi.lhs < gi.rhs_err || (gi.lhs == '0 && gi.err_on)) begin
			r_lvl   = pshm_pkg::LVL_ERROR;
			r_cause = pshm_pkg::CAUSE_RATE_CRIT;
		end else if (gi.lhs < gi.rhs_warn || (gi.lhs == '0 && gi.warn_on)) begin
			r_lvl   = pshm_pkg::LVL_WARN;
			r_cause = pshm_pkg::CAUSE_RATE_LOW;
		end

		level = pshm_pkg::LVL_OK;
		cause = pshm_pkg::CAUSE_OK;
		if (!gi.seen) begin
			level = pshm_pkg::LVL_STALE;
			cause = pshm_pkg::CAUSE_NONE_YET;
		end else if (gi.age > pshm_pkg::TIME_W'(gi.tmo)) begin
			level = pshm_pkg::LVL_STALE;
			cause = pshm_pkg::CAUSE_TIMEOUT;
		end else begin
			if (gi.jump_on && gi.jump_sq > pshm_pkg::JUMP_W'(gi.jump_lim)) begin
				level = pshm_pkg::LVL_ERROR;
				cause = pshm_pkg::CAUSE_JUMP;
			end
			if (t_lvl > level) begin
				level = t_lvl;
				cause = t_cause;
			end
			if (gi.rate_on && r_lvl > level) begin
				level = r_lvl;
				cause = r_cause;
			end
		end
	end

endmodule

// ----- src/pose_stream_health_monitor.sv -----
// ----------------------------------------------------------------------------
// pose_stream_health_monitor: health verdicts for a timestamped pose stream
// Sample storage, 2-second arrival window and graded stream checks.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one request per transaction: tuser selects a
//   pose sample (0) or a status poll (1), tdata carries time and sample
//   fields. Every accepted request yields exactly one verdict transaction
//   on the master stream. Thresholds are set through the APB-style port
//   while the block is idle.
//   One request is processed at a time. A poll passes the two evaluation
//   states to the output register; a sample first enters the window, is
//   pruned, squares and sums its jump, then takes the same evaluation.
//   Pruning runs through the arrival chain one entry per cycle and drops
//   from 0 up to 127 entries after a long gap between samples; the new arrival always stays.
//   The verdict sits in an output register; a stalled receiver does not
//   keep the next request from being accepted and processed, but its
//   verdict waits until the held one is taken.
//   Reset clears the stored pose, the window count and the output valid,
//   and restores the default thresholds. The window chain itself needs no
//   clearing; entries beyond the count are never used.
// ----------------------------------------------------------------------------
module pose_stream_health_monitor (
	input  logic          clk,
	input  logic          arst_n,
	// APB-style configuration port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	// Request stream
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// time_us[47:0], pos_x[71:48], pos_y[95:72], var_xx[127:96], var_yy[159:128]
	input  logic [159:0]  s_axis_tdata,
	// req_type[0]
	input  logic          s_axis_tuser,
	// Verdict stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// level[1:0], cause[4:2], window_count[12:5], window_span_us[33:13],
	// jump_sq[82:34], trace_now[115:83], age_us[163:116], zero fill[167:164]
	output logic [167:0]  m_axis_tdata
);

	localparam int TW = pshm_pkg::TIME_W;
	localparam int N  = pshm_pkg::RING_DEPTH;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SAMP  = 8'b0000_0010,
		ST_PRUNE = 8'b0000_0100,
		ST_SQ    = 8'b0000_1000,
		ST_JSUM  = 8'b0001_0000,
		ST_EV1   = 8'b0010_0000,
		ST_EV2   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	pshm_pkg::cfg_t cfg;

	// Request latch
	logic [TW-1:0]                        time_q;
	logic signed [pshm_pkg::POS_W-1:0]    x_q;
	logic signed [pshm_pkg::POS_W-1:0]    y_q;
	logic [pshm_pkg::VAR_W-1:0]           vxx_q;
	logic [pshm_pkg::VAR_W-1:0]           vyy_q;

	// Stream state
	logic                                 seen_any_q;
	logic [TW-1:0]                        last_arrival_q;
	logic signed [pshm_pkg::POS_W-1:0]    prev_x_q;
	logic signed [pshm_pkg::POS_W-1:0]    prev_y_q;
	logic [pshm_pkg::TRACE_W-1:0]         last_trace_q;
	logic [pshm_pkg::JUMP_W-1:0]          last_jump_q;
	logic [pshm_pkg::FILL_W-1:0]          fill_q;

	// Work registers
	logic                                 had_prev_q;
	logic [pshm_pkg::ABS_W-1:0]           adx_q;
	logic [pshm_pkg::ABS_W-1:0]           ady_q;
	logic [pshm_pkg::SQ_W-1:0]            sqx_s1;
	logic [pshm_pkg::SQ_W-1:0]            sqy_s1;
	logic [pshm_pkg::SPAN_W-1:0]          span_q;
	logic [TW-1:0]                        age_q;
	logic [pshm_pkg::TMO_W-1:0]           tmo_q;
	logic [pshm_pkg::JLIM_W-1:0]          jlim_q;
	logic [pshm_pkg::RPROD_W-1:0]         re_q;
	logic [pshm_pkg::RPROD_W-1:0]         rw_q;
	logic [pshm_pkg::RATE_W-1:0]          lhs_q;
	logic [pshm_pkg::RATE_W-1:0]          rhe_q;
	logic [pshm_pkg::RATE_W-1:0]          rhw_q;

	// Output register
	logic                                 m_valid_q;
	pshm_pkg::level_t                     out_level_q;
	pshm_pkg::cause_t                     out_cause_q;
	logic [pshm_pkg::COUNT_W-1:0]         out_count_q;
	logic [pshm_pkg::SPAN_W-1:0]          out_span_q;
	logic [pshm_pkg::JUMP_W-1:0]          out_jump_q;
	logic [pshm_pkg::TRACE_W-1:0]         out_trace_q;
	logic [TW-1:0]                        out_age_q;

	// Window chain
	pshm_pkg::cell_ctl_t                  cell_ctl;
	logic [N-1:0]                         sel;
	logic [TW-1:0]                        cell_q [N];
	logic [TW-1:0]                        nbr_w  [N];
	logic [pshm_pkg::IDX_W-1:0]           widx;
	logic                                 full;
	logic                                 head_old;
	logic [TW-1:0]                        head_diff;

	logic signed [pshm_pkg::ABS_W-1:0]    dx;
	logic signed [pshm_pkg::ABS_W-1:0]    dy;
	logic                                 s_fire;
	logic                                 out_load;

	pshm_pkg::grade_in_t                  gi;
	pshm_pkg::level_t                     g_level;
	pshm_pkg::cause_t                     g_cause;

	pshm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The oldest arrival always sits in cell 0; cell i hands its entry to
	// cell i-1 when the head drops out of the window.
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == N - 1) begin : g_tail
			assign nbr_w[i] = '0;
		end else begin : g_body
			assign nbr_w[i] = cell_q[i+1];
		end
		assign sel[i] = (pshm_pkg::IDX_W'(i) == widx);
		pshm_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl),
			.sel     (sel[i]),
			.nbr     (nbr_w[i]),
			.entry_q (cell_q[i])
		);
	end

	assign full      = (fill_q == pshm_pkg::FILL_W'(N));
	assign widx      = full ? pshm_pkg::IDX_W'(N - 1) : fill_q[pshm_pkg::IDX_W-1:0];
	assign head_diff = time_q - cell_q[0];
	assign head_old  = (fill_q != '0) && (time_q >= cell_q[0]) && (head_diff > pshm_pkg::WINDOW_US);

	always_comb begin
		cell_ctl.load  = 1'b0;
		cell_ctl.shift = 1'b0;
		cell_ctl.wdata = time_q;
		if (state_q == ST_SAMP) begin
			// A full window drops its oldest entry while the new one goes to the tail.
			cell_ctl.load  = 1'b1;
			cell_ctl.shift = full;
		end else if (state_q == ST_PRUNE) begin
			cell_ctl.shift = head_old;
		end
	end

	assign dx = pshm_pkg::ABS_W'(x_q) - pshm_pkg::ABS_W'(prev_x_q);
	assign dy = pshm_pkg::ABS_W'(y_q) - pshm_pkg::ABS_W'(prev_y_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= (s_axis_tuser == pshm_pkg::REQ_SAMPLE) ? ST_SAMP : ST_EV1;
					end
				end
				ST_SAMP: begin
					state_q <= ST_PRUNE;
				end
				ST_PRUNE: begin
					if (!head_old) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_JSUM;
				end
				ST_JSUM: begin
					state_q <= ST_EV1;
				end
				ST_EV1: begin
					state_q <= ST_EV2;
				end
				ST_EV2: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request latch and work registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			time_q <= s_axis_tdata[47:0];
			x_q    <= s_axis_tdata[71:48];
			y_q    <= s_axis_tdata[95:72];
			vxx_q  <= s_axis_tdata[127:96];
			vyy_q  <= s_axis_tdata[159:128];
		end
		if (state_q == ST_SAMP) begin
			had_prev_q <= seen_any_q;
			adx_q      <= dx[pshm_pkg::ABS_W-1] ? pshm_pkg::ABS_W'(-dx) : pshm_pkg::ABS_W'(dx);
			ady_q      <= dy[pshm_pkg::ABS_W-1] ? pshm_pkg::ABS_W'(-dy) : pshm_pkg::ABS_W'(dy);
		end
		if (state_q == ST_SQ) begin
			sqx_s1 <= pshm_pkg::SQ_W'(adx_q) * pshm_pkg::SQ_W'(adx_q);
			sqy_s1 <= pshm_pkg::SQ_W'(ady_q) * pshm_pkg::SQ_W'(ady_q);
		end
		if (state_q == ST_EV1) begin
			// The newest window entry is always the last arrival.
			if (fill_q >= pshm_pkg::FILL_W'(2) && last_arrival_q > cell_q[0]) begin
				span_q <= pshm_pkg::SPAN_W'(last_arrival_q - cell_q[0]);
			end else begin
				span_q <= '0;
			end
			if (seen_any_q && time_q >= last_arrival_q) begin
				age_q <= time_q - last_arrival_q;
			end else begin
				age_q <= '0;
			end
			tmo_q  <= pshm_pkg::TMO_W'(cfg.stale_timeout_ms) * pshm_pkg::MS_TO_US;
			jlim_q <= pshm_pkg::JLIM_W'(cfg.max_jump_mm) * pshm_pkg::JLIM_W'(cfg.max_jump_mm);
			re_q   <= pshm_pkg::RPROD_W'(cfg.rate_error_ratio)
			          * pshm_pkg::RPROD_W'(cfg.expected_rate);
			rw_q   <= pshm_pkg::RPROD_W'(cfg.rate_warn_ratio)
			          * pshm_pkg::RPROD_W'(cfg.expected_rate);
		end
		if (state_q == ST_EV2) begin
			// Rate test: (count-1) * 1e8 * 256 against ratio * span * expected rate.
			if (fill_q >= pshm_pkg::FILL_W'(2) && span_q != '0) begin
				lhs_q <= pshm_pkg::RATE_W'(fill_q - 1'b1) * pshm_pkg::RATE_K;
			end else begin
				lhs_q <= '0;
			end
			rhe_q <= pshm_pkg::RATE_W'(re_q) * pshm_pkg::RATE_W'(span_q);
			rhw_q <= pshm_pkg::RATE_W'(rw_q) * pshm_pkg::RATE_W'(span_q);
		end
	end

	// Stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_any_q     <= 1'b0;
			last_arrival_q <= '0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			last_trace_q   <= '0;
			last_jump_q    <= '0;
			fill_q         <= '0;
		end else begin
			if (state_q == ST_SAMP) begin
				seen_any_q     <= 1'b1;
				last_arrival_q <= time_q;
				prev_x_q       <= x_q;
				prev_y_q       <= y_q;
				last_trace_q   <= pshm_pkg::TRACE_W'(vxx_q) + pshm_pkg::TRACE_W'(vyy_q);
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == ST_PRUNE && head_old) begin
				fill_q <= fill_q - 1'b1;
			end
			// The first sample has no previous position and keeps the old jump.
			if (state_q == ST_JSUM && had_prev_q) begin
				last_jump_q <= pshm_pkg::JUMP_W'(sqx_s1 + sqy_s1);
			end
		end
	end

	assign gi.seen       = seen_any_q;
	assign gi.age        = age_q;
	assign gi.tmo        = tmo_q;
	assign gi.jump_on    = (cfg.max_jump_mm != '0);
	assign gi.jump_sq    = last_jump_q;
	assign gi.jump_lim   = jlim_q;
	assign gi.trace      = last_trace_q;
	assign gi.trace_warn = cfg.trace_warn_limit;
	assign gi.trace_err  = cfg.trace_error_limit;
	assign gi.rate_on    = (cfg.expected_rate != '0);
	assign gi.err_on     = (cfg.rate_error_ratio != '0);
	assign gi.warn_on    = (cfg.rate_warn_ratio != '0);
	assign gi.lhs        = lhs_q;
	assign gi.rhs_err    = rhe_q;
	assign gi.rhs_warn   = rhw_q;

	pshm_grade u_grade (
		.gi    (gi),
		.level (g_level),
		.cause (g_cause)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q <= g_level;
			out_cause_q <= g_cause;
			out_count_q <= pshm_pkg::COUNT_W'(fill_q);
			out_span_q  <= span_q;
			out_jump_q  <= last_jump_q;
			out_trace_q <= last_trace_q;
			out_age_q   <= age_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0000, out_age_q, out_trace_q, out_jump_q, out_span_q,
	                        out_count_q, out_cause_q, out_level_q};

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the pose stream health monitor
// Drives pose samples and status polls over the request stream, predicts each
// verdict with an independent model of the window, the stored pose and the
// graded checks, and compares every verdict field by field. Threshold sets,
// including the extremes, are loaded over the APB port between phases.
// ----------------------------------------------------------------------------
module tb;
	import pshm_pkg::*;

	localparam int         CYCLE_LIMIT     = 1000000;
	localparam int         PHASES          = 8;
	localparam int         ITEMS_PER_PHASE = 170;
	localparam int         SETTLE_CYCLES   = 200;
	localparam logic [2:0] UNMAPPED_IDX    = 3'd7;
	// Samples per second in 0.01 Hz units times microseconds per second, scaled by 256.
	localparam longint unsigned RATE_SCALE = 64'd25600000000;

	typedef struct {
		level_t               level;
		cause_t               cause;
		logic [COUNT_W-1:0]   count;
		logic [SPAN_W-1:0]    span;
		logic [JUMP_W-1:0]    jump_sq;
		logic [TRACE_W-1:0]   trace;
		logic [TIME_W-1:0]    age;
	} verdict_t;

	class stream_health_tracker;
		logic [RATE_CFG_W-1:0] expected_rate;
		logic [RATIO_W-1:0]    warn_ratio;
		logic [RATIO_W-1:0]    err_ratio;
		logic [TIMEOUT_W-1:0]  stale_ms;
		logic [TRACE_W-1:0]    trace_warn;
		logic [TRACE_W-1:0]    trace_err;
		logic [MAXJUMP_W-1:0]  jump_limit;

		bit                    seen;
		logic [TIME_W-1:0]     last_time;
		logic signed [POS_W-1:0] prev_x;
		logic signed [POS_W-1:0] prev_y;
		logic [TRACE_W-1:0]    last_trace;
		logic [JUMP_W-1:0]     last_jump;
		logic [TIME_W-1:0]     arrivals [RING_DEPTH];
		int unsigned           head;
		int unsigned           fill;

		verdict_t              due_verdicts [$];
		int                    errors;

		function new();
			expected_rate = RST_EXPECTED_RATE;
			warn_ratio    = RST_WARN_RATIO;
			err_ratio     = RST_ERROR_RATIO;
			stale_ms      = RST_TIMEOUT_MS;
			trace_warn    = RST_TRACE_WARN;
			trace_err     = RST_TRACE_ERROR;
			jump_limit    = RST_MAX_JUMP;
			seen          = 1'b0;
			last_time     = '0;
			prev_x        = '0;
			prev_y        = '0;
			last_trace    = '0;
			last_jump     = '0;
			head          = 0;
			fill          = 0;
			errors        = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [63:0] value);
			case (idx)
				REG_EXPECTED_RATE: expected_rate = value[RATE_CFG_W-1:0];
				REG_WARN_RATIO:    warn_ratio    = value[RATIO_W-1:0];
				REG_ERROR_RATIO:   err_ratio     = value[RATIO_W-1:0];
				REG_TIMEOUT_MS:    stale_ms      = value[TIMEOUT_W-1:0];
				REG_TRACE_WARN:    trace_warn    = value[TRACE_W-1:0];
				REG_TRACE_ERROR:   trace_err     = value[TRACE_W-1:0];
				REG_MAX_JUMP:      jump_limit    = value[MAXJUMP_W-1:0];
				default: ;
			endcase
		endfunction

		function verdict_t grade_request(logic kind, logic [159:0] d);
			logic [TIME_W-1:0] now;
			logic [TIME_W-1:0] oldest;
			logic [TIME_W-1:0] newest;
			longint            dx;
			longint            dy;
			longint unsigned   span;
			longint unsigned   age;
			longint unsigned   lhs;
			level_t            lvl;
			level_t            sub_lvl;
			cause_t            why;
			cause_t            sub_why;
			verdict_t          v;

			now = d[47:0];
			if (kind == REQ_SAMPLE) begin
				if (seen) begin
					dx = longint'(signed'(d[71:48])) - longint'(prev_x);
					dy = longint'(signed'(d[95:72])) - longint'(prev_y);
					if (dx < 0) dx = -dx;
					if (dy < 0) dy = -dy;
					last_jump = JUMP_W'(dx * dx + dy * dy);
				end
				last_time  = now;
				seen       = 1'b1;
				last_trace = {1'b0, d[127:96]} + {1'b0, d[159:128]};
				prev_x     = d[71:48];
				prev_y     = d[95:72];
				arrivals[head] = now;
				head = (head + 1) % RING_DEPTH;
				if (fill < RING_DEPTH) fill++;
				// Prune from the oldest end; an entry from the future stops the sweep.
				while (fill > 0) begin
					oldest = arrivals[(head + RING_DEPTH - fill) % RING_DEPTH];
					if (now >= oldest && now - oldest > WINDOW_US) fill--;
					else break;
				end
			end

			span = 0;
			if (fill >= 2) begin
				oldest = arrivals[(head + RING_DEPTH - fill) % RING_DEPTH];
				newest = arrivals[(head + RING_DEPTH - 1) % RING_DEPTH];
				if (newest > oldest) span = newest - oldest;
			end

			age = 0;
			lvl = LVL_OK;
			why = CAUSE_OK;
			if (!seen) begin
				lvl = LVL_STALE;
				why = CAUSE_NONE_YET;
			end else begin
				if (now >= last_time) age = now - last_time;
				if (age > 64'(stale_ms) * 64'd1000) begin
					lvl = LVL_STALE;
					why = CAUSE_TIMEOUT;
				end else begin
					if (jump_limit != 0 && last_jump > 64'(jump_limit) * 64'(jump_limit)) begin
						lvl = LVL_ERROR;
						why = CAUSE_JUMP;
					end
					sub_lvl = LVL_OK;
					sub_why = CAUSE_OK;
					if (last_trace > trace_err) begin
						sub_lvl = LVL_ERROR;
						sub_why = CAUSE_COV_CRIT;
					end else if (last_trace > trace_warn) begin
						sub_lvl = LVL_WARN;
						sub_why = CAUSE_COV_HIGH;
					end
					if (sub_lvl > lvl) begin
						lvl = sub_lvl;
						why = sub_why;
					end
					if (expected_rate != 0) begin
						// Measured over expected below ratio/256, cross-multiplied.
						lhs = (fill >= 2 && span > 0) ? 64'(fill - 1) * RATE_SCALE : 64'd0;
						sub_lvl = LVL_OK;
						sub_why = CAUSE_OK;
						if (lhs < 64'(err_ratio) * span * 64'(expected_rate) ||
								(lhs == 0 && err_ratio != 0)) begin
							sub_lvl = LVL_ERROR;
							sub_why = CAUSE_RATE_CRIT;
						end else if (lhs < 64'(warn_ratio) * span * 64'(expected_rate) ||
								(lhs == 0 && warn_ratio != 0)) begin
							sub_lvl = LVL_WARN;
							sub_why = CAUSE_RATE_LOW;
						end
						if (sub_lvl > lvl) begin
							lvl = sub_lvl;
							why = sub_why;
						end
					end
				end
			end

			v.level   = lvl;
			v.cause   = why;
			v.count   = COUNT_W'(fill);
			v.span    = SPAN_W'(span);
			v.jump_sq = last_jump;
			v.trace   = last_trace;
			v.age     = TIME_W'(age);
			return v;
		endfunction

		function void note_request(logic kind, logic [159:0] d);
			verdict_t v;
			v = grade_request(kind, d);
			due_verdicts.insert(due_verdicts.size(), v);
		endfunction

		function int pending_count();
			return due_verdicts.size();
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_verdict(logic [167:0] d);
			verdict_t want;
			if (due_verdicts.size() == 0) begin
				errors++;
				$display("%0t: verdict expected none actual %h", $time, d);
				return;
			end
			want = due_verdicts[0];
			due_verdicts.delete(0);
			check_field("level", want.level, d[1:0]);
			check_field("cause", want.cause, d[4:2]);
			check_field("window_count", want.count, d[12:5]);
			check_field("window_span_us", want.span, d[33:13]);
			check_field("jump_sq", want.jump_sq, d[82:34]);
			check_field("trace_now", want.trace, d[115:83]);
			check_field("age_us", want.age, d[163:116]);
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [5:0]    paddr;
	logic [63:0]   pwdata;
	logic [63:0]   prdata;
	logic          pready;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [159:0]  s_axis_tdata;
	logic          s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [167:0]  m_axis_tdata;

	stream_health_tracker    tracker;
	int                      src_idle_pct;
	int                      snk_stall_pct;
	int                      cycles;
	int                      burst_left;
	logic [TIME_W-1:0]       walk_time;
	logic signed [POS_W-1:0] walk_x;
	logic signed [POS_W-1:0] walk_y;

	pose_stream_health_monitor u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("pose_stream_health_monitor: mismatch");
			$finish;
		end
	end

	// Values sampled here are the ones seen just before the edge.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tracker.note_request(s_axis_tuser, s_axis_tdata);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_verdict(m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic write_thresholds(input logic [63:0] rate, input logic [63:0] warn,
			input logic [63:0] err, input logic [63:0] tmo, input logic [63:0] tw,
			input logic [63:0] te, input logic [63:0] jmp);
		write_register(REG_EXPECTED_RATE, rate);
		write_register(REG_WARN_RATIO, warn);
		write_register(REG_ERROR_RATIO, err);
		write_register(REG_TIMEOUT_MS, tmo);
		write_register(REG_TRACE_WARN, tw);
		write_register(REG_TRACE_ERROR, te);
		write_register(REG_MAX_JUMP, jmp);
	endtask

	task automatic wait_verdicts_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending_count() != 0);
	endtask

	task automatic send_item(input logic kind, input logic [159:0] payload);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= payload;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_sample(input logic [47:0] t, input logic [23:0] x, input logic [23:0] y,
			input logic [31:0] vx, input logic [31:0] vy);
		send_item(REQ_SAMPLE, {vy, vx, y, x, t});
	endtask

	task automatic send_poll(input logic [47:0] t);
		// The pose fields of a poll carry noise that must be ignored.
		send_item(REQ_POLL, {$urandom, $urandom, 16'($urandom), $urandom, t});
	endtask

	task automatic send_random_request();
		int          pick;
		logic [31:0] vx;
		logic [31:0] vy;

		pick = $urandom_range(99);
		if (pick < 22) begin
			pick = $urandom_range(9);
			if (pick == 0) send_poll(walk_time + 48'($urandom_range(3000000)));
			else if (pick == 1) send_poll(walk_time - 48'($urandom_range(50000)));
			else send_poll(walk_time + 48'($urandom_range(400000)));
			return;
		end

		if (burst_left > 0) begin
			burst_left--;
			walk_time += 48'($urandom_range(12000, 1000));
		end else begin
			pick = $urandom_range(999);
			if (pick < 6) burst_left = $urandom_range(180, 130);
			pick = $urandom_range(99);
			if (pick < 60) walk_time += 48'($urandom_range(60000, 5000));
			else if (pick < 75) walk_time += 48'($urandom_range(8000));
			else if (pick < 87) walk_time += 48'($urandom_range(3000000, 200000));
			else if (pick < 92) walk_time = {16'($urandom), $urandom};
			else if (pick < 96) walk_time -= 48'($urandom_range(100000, 1));
		end

		pick = $urandom_range(9);
		if (pick < 8) begin
			walk_x = walk_x + 24'(int'($urandom_range(4000)) - 2000);
			walk_y = walk_y + 24'(int'($urandom_range(4000)) - 2000);
		end else if (pick == 8) begin
			walk_x = 24'($urandom);
			walk_y = 24'($urandom);
		end else begin
			walk_x = walk_x + 24'(int'($urandom_range(20000)) - 10000);
			walk_y = walk_y + 24'(int'($urandom_range(20000)) - 10000);
		end

		pick = $urandom_range(9);
		if (pick < 6) begin
			vx = $urandom_range(300000);
			vy = $urandom_range(300000);
		end else if (pick < 8) begin
			vx = $urandom;
			vy = $urandom;
		end else begin
			vx = $urandom_range(3000000);
			vy = $urandom_range(30000);
		end
		send_sample(walk_time, walk_x, walk_y, vx, vy);
	endtask

	task automatic apply_thresholds(input int which);
		case (which)
			0: write_thresholds(RST_EXPECTED_RATE, RST_WARN_RATIO, RST_ERROR_RATIO,
				RST_TIMEOUT_MS, RST_TRACE_WARN, RST_TRACE_ERROR, RST_MAX_JUMP);
			1: begin
				write_thresholds('1, '1, '1, '1, '1, '1, '1);
				write_register(UNMAPPED_IDX, {$urandom, $urandom});
			end
			2: write_thresholds('0, '0, '0, '0, '0, '0, '0);
			default: write_thresholds($urandom_range(100000), $urandom_range(256),
				$urandom_range(256), $urandom_range(3000), $urandom_range(1000000),
				$urandom_range(3000000), $urandom_range(5000));
		endcase
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_SAMPLE;
		m_axis_tready = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		cycles        = 0;
		burst_left    = 0;
		walk_time     = '0;
		walk_x        = '0;
		walk_y        = '0;
		tracker       = new();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset thresholds.
		send_poll(48'd0);
		send_sample(48'd1000, 24'd0, 24'd0, 32'd0, 32'd0);
		// Jump exactly at the limit, trace exactly at the warn level, rate a bit low.
		send_sample(48'd51000, 24'd2000, 24'd0, 32'd32768, 32'd32768);
		send_sample(48'd84333, 24'd4001, 24'd0, 32'd32768, 32'd32769);
		send_sample(48'd117666, 24'h7FFFFF, 24'h800000, 32'd300000, 32'd289824);
		// Largest jump together with a critical trace: the jump keeps the cause.
		send_sample(48'd151000, 24'h800000, 24'h7FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_sample(48'd184333, 24'h800000, 24'h7FFFFF, 32'd0, 32'd0);
		send_poll(48'd1184333);
		send_poll(48'd1184334);
		send_poll(48'd100);
		send_sample(48'd150000, 24'hFFFFFF, 24'd1, 32'd1, 32'd1);
		send_sample(48'hFFFF_FFFF_FFFF, 24'd0, 24'd0, 32'd1000, 32'd1000);
		send_sample(48'hFFFF_FFFF_FFFF, 24'd0, 24'd0, 32'd1000, 32'd1000);
		send_sample(48'd5, 24'd10, 24'd10, 32'd1000, 32'd1000);
		send_poll(48'hFFFF_FFFF_FFFF);
		walk_time = 48'd5;

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_verdicts_drained();
			apply_thresholds(phase);
			case (phase % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
				default: begin src_idle_pct = 20; snk_stall_pct = 20; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_request();
		end

		wait_verdicts_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("pose_stream_health_monitor: match");
		else
			$display("pose_stream_health_monitor: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
src/pshm_pkg.sv
src/pshm_cell.sv
src/pshm_regs.sv
src/pshm_grade.sv
src/pose_stream_health_monitor.sv
tb/tb.sv
